[rtl/sbda_pkg.sv]
// Package for the signed binary to decimal ASCII converter.
// Holds the widths, character codes and pipeline payload types; depends on nothing.
package sbda_pkg;

	localparam int ValueW       = 32;
	localparam int NumDigits    = 10;
	localparam int DigitW       = 4;
	localparam int BcdW         = NumDigits * DigitW;
	localparam int BitsPerStage = 4;
	localparam int NumStages    = ValueW / BitsPerStage;
	localparam int DigitIdxW    = $clog2(NumDigits);
	localparam int CharW        = 7;

	localparam logic [CharW-1:0] CodeZero  = 7'd48;
	localparam logic [CharW-1:0] CodeMinus = 7'd45;

	// Shift-and-add-3 working set: decimal digits above, binary bits still to go below.
	typedef struct packed {
		logic              neg;
		logic [BcdW-1:0]   bcd;
		logic [ValueW-1:0] bin;
	} dab_t;

	// Finished conversion handed to the character serialiser.
	typedef struct packed {
		logic                 neg;
		logic [BcdW-1:0]      bcd;
		logic [DigitIdxW-1:0] top_idx;
	} ser_t;

endpackage

[rtl/sbda_dabble_stage.sv]
// One pipeline stage of the binary to BCD conversion: BitsPerStage shift-and-add-3 steps.
// Depends on sbda_pkg for the payload type and step count.
module sbda_dabble_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sbda_pkg::dab_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sbda_pkg::dab_t out_data
);
	import sbda_pkg::*;

	logic valid_s;
	dab_t data_s;
	dab_t next_data;

	always_comb begin
		logic [BcdW+ValueW-1:0] sr;
		logic [DigitW-1:0]      d;
		sr = {in_data.bcd, in_data.bin};
		for (int it = 0; it < BitsPerStage; it++) begin
			for (int k = 0; k < NumDigits; k++) begin
				d = sr[ValueW + k*DigitW +: DigitW];
				if (d >= 4'd5) begin
					d = d + 4'd3;
				end
				sr[ValueW + k*DigitW +: DigitW] = d;
			end
			sr = {sr[BcdW+ValueW-2:0], 1'b0};
		end
		next_data.neg = in_data.neg;
		next_data.bcd = sr[BcdW+ValueW-1:ValueW];
		next_data.bin = sr[ValueW-1:0];
	end

	assign in_ready  = !valid_s || out_ready;
	assign out_valid = valid_s;
	assign out_data  = data_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s <= next_data;
		end
	end

endmodule

[rtl/sbda_serializer.sv]
// Character serialiser: sends an optional minus sign, then the digits from the top.
// Depends on sbda_pkg for the conversion type and the character codes.
module sbda_serializer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sbda_pkg::ser_t               in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sbda_pkg::CharW-1:0]   char_code,
	output logic                         last_char
);
	import sbda_pkg::*;

	logic                 busy_q;
	logic                 neg_q;
	logic [DigitIdxW-1:0] idx_q;
	logic [DigitW-1:0]    digit_q [NumDigits];
	logic                 done;

	assign out_valid = busy_q;
	assign last_char = !neg_q && (idx_q == '0);
	assign char_code = neg_q ? CodeMinus : CodeZero + {{(CharW-DigitW){1'b0}}, digit_q[idx_q]};
	assign done      = out_ready && last_char;
	assign in_ready  = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			idx_q  <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			if (in_valid) begin
				neg_q <= in_data.neg;
				idx_q <= in_data.top_idx;
			end
		end else if (out_ready) begin
			// The sign goes out first; the digit index only moves after it.
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int k = 0; k < NumDigits; k++) begin
				digit_q[k] <= in_data.bcd[k*DigitW +: DigitW];
			end
		end
	end

endmodule

[rtl/signed_binary_to_decimal_ascii_core.sv]
// Top level of the signed binary to decimal ASCII converter.
// Depends on sbda_pkg, sbda_dabble_stage and sbda_serializer.
//
// Each accepted request carries one signed 32-bit value; the block answers with its decimal
// text, one ASCII character per output request, most significant first, with a leading '-'
// for negative values, no leading zeros and last_char set on the final character. The
// conversion is a ten-stage pipeline (magnitude, eight shift-and-add-3 stages of four bits
// each, leading-digit search). The single-character output channel sets the sustained rate:
// a number holds it until all of its characters, from 1 to 11, are taken, and the next
// number's first character follows its last with no gap when that number is waiting.
// Meanwhile further values are taken into the pipeline until it fills.
module signed_binary_to_decimal_ascii_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbda_pkg::CharW-1:0]  char_code,
	output logic                        last_char
);
	import sbda_pkg::*;

	logic valid_s1;
	dab_t dab_s1;
	logic valid_s10;
	ser_t ser_s10;
	logic ser_ready;
	logic en_s10;

	logic stg_valid [NumStages+1];
	logic stg_ready [NumStages+1];
	dab_t stg_data  [NumStages+1];

	logic [DigitIdxW-1:0] top_idx;

	// Input stage: sign and magnitude. The most negative value negates onto itself,
	// which is its correct unsigned magnitude.
	assign in_ready = !valid_s1 || stg_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dab_s1.neg <= value[ValueW-1];
			dab_s1.bcd <= '0;
			dab_s1.bin <= value[ValueW-1] ? (~value + 32'd1) : value;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_data[0]  = dab_s1;

	for (genvar g = 0; g < NumStages; g++) begin : g_dabble
		sbda_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	// Leading-digit search: index of the highest non-zero digit, or zero for a value of zero.
	always_comb begin
		top_idx = '0;
		for (int k = 1; k < NumDigits; k++) begin
			if (stg_data[NumStages].bcd[k*DigitW +: DigitW] != '0) begin
				top_idx = DigitIdxW'(k);
			end
		end
	end

	assign en_s10               = !valid_s10 || ser_ready;
	assign stg_ready[NumStages] = en_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (en_s10) begin
			valid_s10 <= stg_valid[NumStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10 && stg_valid[NumStages]) begin
			ser_s10.neg     <= stg_data[NumStages].neg;
			ser_s10.bcd     <= stg_data[NumStages].bcd;
			ser_s10.top_idx <= top_idx;
		end
	end

	sbda_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s10),
		.in_ready  (ser_ready),
		.in_data   (ser_s10),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule
